[design/swo_pkg.sv]
// Shared constants for the sliding-window OR unit.
package swo_pkg;

    localparam int WINDOW_MAX_DEF = 1024;
    localparam int VALUE_BITS_DEF = 32;

    localparam int CFG_W        = 11;
    localparam int SAMPLE_W     = 32;
    localparam int RESULT_W     = 32;
    localparam int S_TDATA_W    = SAMPLE_W;
    localparam int S_TUSER_W    = 1;
    localparam int M_TDATA_W    = 2 * RESULT_W;
    localparam int M_TUSER_W    = 1;

endpackage

[design/swo_ram.sv]
// Simple dual-port synchronous RAM with registered read.
module swo_ram #(
    parameter  int DEPTH  = swo_pkg::WINDOW_MAX_DEF,
    parameter  int DATA_W = swo_pkg::VALUE_BITS_DEF,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[design/sliding_window_or_unit.sv]
// Top level of the sliding-window OR unit: two-stack queue over two RAMs.
//
//  channel   direction  handshake                      payload
//  s_axis    in         s_axis_tvalid/s_axis_tready    tdata: sample_value; tuser: restart
//  m_axis    out        m_axis_tvalid/m_axis_tready    tdata: window_or, xor_of_ors;
//                                                      tuser: window_full
//  cfg       in         cfg_we                         cfg_wdata: window_size
//
//  Steps per word in steady state: accept, drop oldest, push plus older-stack
//  read, result. When the older stack runs empty, the words of the newer stack
//  are moved to it one read at a time through the single read port of the
//  newer-stack RAM. Each extra drop after a window_size decrease adds one more
//  pass through the check step.
//  Reset: counts, accumulator and control clear at once; no RAM clearing pass.
//  Stalls: one result register; the next word is taken while a result waits.
module sliding_window_or_unit #(
    parameter int WINDOW_MAX = swo_pkg::WINDOW_MAX_DEF,
    parameter int VALUE_BITS = swo_pkg::VALUE_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [swo_pkg::S_TDATA_W-1:0]  s_axis_tdata,   // [31:0] sample_value
    input  logic [swo_pkg::S_TUSER_W-1:0]  s_axis_tuser,   // [0] restart
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [swo_pkg::M_TDATA_W-1:0]  m_axis_tdata,   // [31:0] window_or, [63:32] xor_of_ors
    output logic [swo_pkg::M_TUSER_W-1:0]  m_axis_tuser,   // [0] window_full
    input  logic                           cfg_we,
    input  logic [swo_pkg::CFG_W-1:0]      cfg_wdata
);

    localparam int ADDR_W = $clog2(WINDOW_MAX);
    localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
    localparam int CMP_W  = (CNT_W + 1 > swo_pkg::CFG_W) ? CNT_W + 1 : swo_pkg::CFG_W;
    localparam int WB     = (VALUE_BITS > swo_pkg::SAMPLE_W) ? VALUE_BITS : swo_pkg::SAMPLE_W;

    typedef enum logic [1:0] {ST_IDLE, ST_CHECK, ST_XFER, ST_RESULT} state_t;

    state_t                    state_reg, state_next;
    logic [swo_pkg::CFG_W-1:0] wsize_reg, wsize_next;
    logic [VALUE_BITS-1:0]     value_reg, value_next;
    logic [CNT_W-1:0]          newer_cnt_reg, newer_cnt_next;
    logic [CNT_W-1:0]          older_cnt_reg, older_cnt_next;
    logic [VALUE_BITS-1:0]     newer_or_reg, newer_or_next;
    logic [VALUE_BITS-1:0]     acc_reg, acc_next;
    logic                      older_nz_reg, older_nz_next;
    logic [CNT_W-1:0]          rd_left_reg, rd_left_next;
    logic [CNT_W-1:0]          wr_idx_reg, wr_idx_next;
    logic                      pend_reg, pend_next;
    logic [VALUE_BITS-1:0]     run_or_reg, run_or_next;
    logic                      out_valid_reg, out_valid_next;
    logic [VALUE_BITS-1:0]     out_or_reg, out_or_next;
    logic [VALUE_BITS-1:0]     out_xor_reg, out_xor_next;
    logic                      out_full_reg, out_full_next;

    logic                      newer_we;
    logic [ADDR_W-1:0]         newer_waddr;
    logic                      newer_re;
    logic [ADDR_W-1:0]         newer_raddr;
    logic [VALUE_BITS-1:0]     newer_rdata;
    logic                      older_we;
    logic [ADDR_W-1:0]         older_waddr;
    logic [VALUE_BITS-1:0]     older_wdata;
    logic                      older_re;
    logic [ADDR_W-1:0]         older_raddr;
    logic [VALUE_BITS-1:0]     older_rdata;

    logic [CMP_W-1:0]          ws_ext;
    logic [CMP_W-1:0]          eff;
    logic [CMP_W-1:0]          total;
    logic [CNT_W-1:0]          older_m1;
    logic [CNT_W-1:0]          newer_m1;
    logic [CNT_W-1:0]          rd_m1;
    logic [WB-1:0]             sample_wide;
    logic [WB-1:0]             or_wide;
    logic [WB-1:0]             xor_wide;
    logic                      s_fire;
    logic                      m_free;
    logic [VALUE_BITS-1:0]     agg;
    logic                      full;
    logic [VALUE_BITS-1:0]     xfer_or;

    swo_ram #(.DEPTH(WINDOW_MAX), .DATA_W(VALUE_BITS)) u_newer_ram (
        .clk   (clk),
        .we    (newer_we),
        .waddr (newer_waddr),
        .wdata (value_reg),
        .re    (newer_re),
        .raddr (newer_raddr),
        .rdata (newer_rdata)
    );

    swo_ram #(.DEPTH(WINDOW_MAX), .DATA_W(VALUE_BITS)) u_older_ram (
        .clk   (clk),
        .we    (older_we),
        .waddr (older_waddr),
        .wdata (older_wdata),
        .re    (older_re),
        .raddr (older_raddr),
        .rdata (older_rdata)
    );

    assign ws_ext = CMP_W'(wsize_reg);
    assign eff    = (ws_ext == '0) ? CMP_W'(1) :
                    (ws_ext > CMP_W'(WINDOW_MAX)) ? CMP_W'(WINDOW_MAX) : ws_ext;
    assign total  = CMP_W'(newer_cnt_reg) + CMP_W'(older_cnt_reg);

    assign older_m1    = older_cnt_reg - CNT_W'(1);
    assign newer_m1    = newer_cnt_reg;
    assign rd_m1       = rd_left_reg - CNT_W'(1);
    assign sample_wide = WB'(s_axis_tdata);
    assign xfer_or     = newer_rdata | run_or_reg;

    assign s_fire = s_axis_tvalid && s_axis_tready;
    assign m_free = !out_valid_reg || m_axis_tready;
    assign agg    = newer_or_reg | (older_nz_reg ? older_rdata : '0);
    assign full   = (total == eff);

    always_comb
    begin
        state_next     = state_reg;
        wsize_next     = wsize_reg;
        value_next     = value_reg;
        newer_cnt_next = newer_cnt_reg;
        older_cnt_next = older_cnt_reg;
        newer_or_next  = newer_or_reg;
        acc_next       = acc_reg;
        older_nz_next  = older_nz_reg;
        rd_left_next   = rd_left_reg;
        wr_idx_next    = wr_idx_reg;
        pend_next      = 1'b0;
        run_or_next    = run_or_reg;
        out_valid_next = out_valid_reg;
        out_or_next    = out_or_reg;
        out_xor_next   = out_xor_reg;
        out_full_next  = out_full_reg;
        newer_we       = 1'b0;
        newer_waddr    = newer_m1[ADDR_W-1:0];
        newer_re       = 1'b0;
        newer_raddr    = rd_m1[ADDR_W-1:0];
        older_we       = 1'b0;
        older_waddr    = wr_idx_reg[ADDR_W-1:0];
        older_wdata    = xfer_or;
        older_re       = 1'b0;
        older_raddr    = older_m1[ADDR_W-1:0];

        if (cfg_we)
        begin
            wsize_next = cfg_wdata;
        end

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_fire)
                begin
                    value_next = sample_wide[VALUE_BITS-1:0];
                    if (s_axis_tuser[0])
                    begin
                        newer_cnt_next = '0;
                        older_cnt_next = '0;
                        newer_or_next  = '0;
                        acc_next       = '0;
                    end
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (total >= eff)
                begin
                    if (older_cnt_reg == '0)
                    begin
                        rd_left_next = newer_cnt_reg;
                        wr_idx_next  = '0;
                        run_or_next  = '0;
                        state_next   = ST_XFER;
                    end
                    else
                    begin
                        older_cnt_next = older_m1;
                    end
                end
                else
                begin
                    newer_we       = 1'b1;
                    newer_cnt_next = newer_cnt_reg + CNT_W'(1);
                    newer_or_next  = newer_or_reg | value_reg;
                    older_re       = (older_cnt_reg != '0);
                    older_nz_next  = (older_cnt_reg != '0);
                    state_next     = ST_RESULT;
                end
            end
            ST_XFER:
            begin
                if (rd_left_reg != '0)
                begin
                    newer_re     = 1'b1;
                    rd_left_next = rd_m1;
                    pend_next    = 1'b1;
                end
                if (pend_reg)
                begin
                    older_we    = 1'b1;
                    run_or_next = xfer_or;
                    wr_idx_next = wr_idx_reg + CNT_W'(1);
                end
                if (rd_left_reg == '0 && !pend_reg)
                begin
                    older_cnt_next = wr_idx_reg - CNT_W'(1);
                    newer_cnt_next = '0;
                    newer_or_next  = '0;
                    state_next     = ST_CHECK;
                end
            end
            ST_RESULT:
            begin
                if (m_free)
                begin
                    acc_next       = full ? (acc_reg ^ agg) : acc_reg;
                    out_or_next    = agg;
                    out_xor_next   = full ? (acc_reg ^ agg) : acc_reg;
                    out_full_next  = full;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wsize_reg     <= swo_pkg::CFG_W'(1);
            value_reg     <= '0;
            newer_cnt_reg <= '0;
            older_cnt_reg <= '0;
            newer_or_reg  <= '0;
            acc_reg       <= '0;
            older_nz_reg  <= 1'b0;
            rd_left_reg   <= '0;
            wr_idx_reg    <= '0;
            pend_reg      <= 1'b0;
            run_or_reg    <= '0;
            out_valid_reg <= 1'b0;
            out_or_reg    <= '0;
            out_xor_reg   <= '0;
            out_full_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wsize_reg     <= wsize_next;
            value_reg     <= value_next;
            newer_cnt_reg <= newer_cnt_next;
            older_cnt_reg <= older_cnt_next;
            newer_or_reg  <= newer_or_next;
            acc_reg       <= acc_next;
            older_nz_reg  <= older_nz_next;
            rd_left_reg   <= rd_left_next;
            wr_idx_reg    <= wr_idx_next;
            pend_reg      <= pend_next;
            run_or_reg    <= run_or_next;
            out_valid_reg <= out_valid_next;
            out_or_reg    <= out_or_next;
            out_xor_reg   <= out_xor_next;
            out_full_reg  <= out_full_next;
        end
    end

    assign or_wide  = WB'(out_or_reg);
    assign xor_wide = WB'(out_xor_reg);

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {xor_wide[swo_pkg::RESULT_W-1:0], or_wide[swo_pkg::RESULT_W-1:0]};
    assign m_axis_tuser  = out_full_reg;

    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CMP_W'(newer_cnt_reg) + CMP_W'(older_cnt_reg) <= CMP_W'(WINDOW_MAX))
        else $error("window count exceeds capacity");

    a_xfer_empties_newer: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_XFER && rd_left_reg == '0 && !pend_reg) |=>
            (newer_cnt_reg == '0 && state_reg == ST_CHECK))
        else $error("stack move left words on newer stack");

    a_result_from_result_state: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_RESULT))
        else $error("result loaded outside result state");

    a_accept_to_check: assert property (@(posedge clk) disable iff (!rst_n)
        s_fire |=> (state_reg == ST_CHECK))
        else $error("accepted word not processed");

    a_push_below_bound: assert property (@(posedge clk) disable iff (!rst_n)
        newer_we |-> (newer_cnt_reg < CNT_W'(WINDOW_MAX)))
        else $error("push onto full newer stack");

endmodule
